>>> design/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  // default sizing of the partition table
  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_SIZE_BITS      = 16;

  // fixed field widths of the item interfaces
  localparam int INDEX_W = 4;
  localparam int REQ_W   = 16;
  localparam int LEFT_W  = 16;
  localparam int COUNT_W = 5;
  localparam int STRAT_W = 2;

  // packed stream widths, padded to whole bytes
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // item kind carried in tuser
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // search strategies
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd2;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESULT
  } state_e;

  // control from the sequencer to the shared fit unit
  typedef struct packed {
    logic clear;
    logic eval;
    logic first_mode;
    logic worst;
  } fit_ctrl_t;

endpackage

>>> design/pfa_ram.sv
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pfa_fit_unit.sv
`timescale 1ns / 1ps

module pfa_fit_unit #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS,
  localparam int IdxW          = $clog2(MAX_PARTITIONS),
  localparam int CmpW          = (SIZE_BITS > pfa_pkg::REQ_W) ? SIZE_BITS : pfa_pkg::REQ_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pfa_pkg::fit_ctrl_t       ctrl_i,
  input  logic [pfa_pkg::REQ_W-1:0] req_i,
  input  logic [SIZE_BITS-1:0]     size_i,
  input  logic                     alloc_i,
  input  logic [IdxW-1:0]          idx_i,
  output logic                     found_o,
  output logic [IdxW-1:0]          pick_o,
  output logic [CmpW-1:0]          frag_o
);

  import pfa_pkg::*;

  logic            have_q, have_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic [CmpW-1:0] keep_q, keep_d;
  logic [CmpW-1:0] size_ext, req_ext, frag;
  logic            fits, better, take;

  // one compare and subtract per candidate
  always_comb begin
    size_ext = CmpW'(size_i);
    req_ext  = CmpW'(req_i);
    frag     = size_ext - req_ext;
    fits     = !alloc_i && (size_ext >= req_ext);
    better   = ctrl_i.worst ? (frag > keep_q) : (frag < keep_q);
    take     = ctrl_i.eval && fits && (!have_q || (!ctrl_i.first_mode && better));
  end

  // running pick
  always_comb begin
    have_d = have_q;
    pick_d = pick_q;
    keep_d = keep_q;
    if (ctrl_i.clear) begin
      have_d = 1'b0;
      pick_d = '0;
      keep_d = '0;
    end else if (take) begin
      have_d = 1'b1;
      pick_d = idx_i;
      keep_d = frag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pick_q <= '0;
      keep_q <= '0;
    end else begin
      have_q <= have_d;
      pick_q <= pick_d;
      keep_q <= keep_d;
    end
  end

  assign found_o = have_q;
  assign pick_o  = pick_q;
  assign frag_o  = keep_q;

  // a cleared unit holds no pick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !have_q && (keep_q == '0))
    else $error("fit unit not cleared");

  // first and next fit keep the earliest hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q && ctrl_i.first_mode && !ctrl_i.clear |=> $stable(pick_q))
    else $error("first-fit pick replaced");

endmodule

>>> design/partition_fit_allocator.sv
`timescale 1ns / 1ps

// Fixed-partition allocator with best, first, next and worst fit. A load item
// (tuser = 0) writes one partition size and frees it; a request item (tuser = 1)
// scans the active partitions through a single compare/subtract unit, one
// partition per cycle from the size RAM's registered read port, marks the
// granted partition allocated and returns found, index and leftover. A load
// goes straight from idle to the result state, as does a request when n, the
// active partition count, is zero; other requests pass the scan and last states.
// The input is not ready while an item is in work; a finished result sits in
// the output register until taken. The partition sizes are undefined until loaded.
module partition_fit_allocator #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // block_index[3:0], block_size[19:4], request_size[35:20], strategy[37:36]
  input  logic [pfa_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // mode[0]
  input  logic                         s_axis_tuser_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // granted_index[3:0], leftover[19:4]
  output logic [pfa_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // found[0]
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic [pfa_pkg::COUNT_W-1:0]  cfg_data_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o
);

  import pfa_pkg::*;

  localparam int IdxW = $clog2(MAX_PARTITIONS);
  localparam int CntW = $clog2(MAX_PARTITIONS + 1);
  localparam int CmpW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  // input fields
  logic [INDEX_W-1:0] in_index;
  logic [REQ_W-1:0]   in_bsize, in_req;
  logic [STRAT_W-1:0] in_strat;

  assign in_index = s_axis_tdata_i[INDEX_W-1:0];
  assign in_bsize = s_axis_tdata_i[INDEX_W +: REQ_W];
  assign in_req   = s_axis_tdata_i[INDEX_W+REQ_W +: REQ_W];
  assign in_strat = s_axis_tdata_i[INDEX_W+2*REQ_W +: STRAT_W];

  state_e state_q, state_d;

  logic [COUNT_W-1:0]        count_q;
  logic [MAX_PARTITIONS-1:0] alloc_q, alloc_d;
  logic [IdxW-1:0]           ptr_q, ptr_d;
  logic [CntW-1:0]           n_q, n_d, n_sat;
  logic [REQ_W-1:0]          req_q, req_d;
  logic                      next_q, next_d;
  logic                      first_q, first_d;
  logic                      worst_q, worst_d;
  logic [IdxW-1:0]           addr_q, addr_d;
  logic [CntW-1:0]           iss_q, iss_d;
  logic                      rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]           rd_idx_q, rd_idx_d;

  logic                      accept, is_load, load_ok;
  logic                      issue, res_load, slot_free;
  logic                      last_issue;
  fit_ctrl_t                 fit_ctrl;
  logic                      fit_found;
  logic [IdxW-1:0]           fit_pick;
  logic [CmpW-1:0]           fit_frag;
  logic [SIZE_BITS-1:0]      rd_size;

  logic                      m_valid_q;
  logic                      m_found_q, m_found_d;
  logic [INDEX_W-1:0]        m_index_q, m_index_d;
  logic [LEFT_W-1:0]         m_left_q, m_left_d;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(16);
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // active count saturated to the table depth
  assign n_sat = (int'(count_q) > MAX_PARTITIONS) ? CntW'(MAX_PARTITIONS) : CntW'(count_q);

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load    = (s_axis_tuser_i == MODE_LOAD);
  assign load_ok    = accept && is_load && (int'(in_index) < MAX_PARTITIONS);
  assign slot_free  = !m_valid_q || m_axis_tready_i;
  assign last_issue = (iss_q == n_q - CntW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_load || (n_sat == '0)) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o     = 1'b0;
    issue               = 1'b0;
    res_load            = 1'b0;
    fit_ctrl.clear      = 1'b0;
    fit_ctrl.eval       = rd_valid_q;
    fit_ctrl.first_mode = first_q;
    fit_ctrl.worst      = worst_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        fit_ctrl.clear  = accept;
      end
      ST_SCAN: begin
        issue = 1'b1;
      end
      ST_LAST: begin
      end
      ST_RESULT: begin
        res_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // request context and scan address stepping
  always_comb begin
    n_d        = n_q;
    req_d      = req_q;
    next_d     = next_q;
    first_d    = first_q;
    worst_d    = worst_q;
    addr_d     = addr_q;
    iss_d      = iss_q;
    rd_valid_d = issue;
    rd_idx_d   = issue ? addr_q : rd_idx_q;
    if (accept) begin
      n_d     = n_sat;
      req_d   = in_req;
      // only a request over a non-empty table moves the pointer
      next_d  = (in_strat == STRAT_NEXT) && !is_load && (n_sat != '0);
      first_d = (in_strat == STRAT_FIRST) || (in_strat == STRAT_NEXT);
      worst_d = (in_strat == STRAT_WORST);
      iss_d   = '0;
      if ((in_strat == STRAT_NEXT) && (CntW'(ptr_q) < n_sat)) begin
        addr_d = ptr_q;
      end else begin
        addr_d = '0;
      end
    end else if (issue) begin
      iss_d = iss_q + CntW'(1);
      if (CntW'(addr_q) == n_q - CntW'(1)) begin
        addr_d = '0;
      end else begin
        addr_d = addr_q + IdxW'(1);
      end
    end
  end

  // result, allocated marks and next-fit pointer
  always_comb begin
    alloc_d   = alloc_q;
    ptr_d     = ptr_q;
    m_found_d = fit_found;
    m_index_d = fit_found ? INDEX_W'(fit_pick) : '0;
    m_left_d  = '0;
    if (fit_found) begin
      m_left_d = (fit_frag > CmpW'(LEFT_W'('1))) ? '1 : LEFT_W'(fit_frag);
    end
    if (load_ok) begin
      alloc_d[IdxW'(in_index)] = 1'b0;
    end
    if (res_load) begin
      if (fit_found) begin
        alloc_d[fit_pick] = 1'b1;
      end
      if (next_q) begin
        if (fit_found && (CntW'(fit_pick) != n_q - CntW'(1))) begin
          ptr_d = fit_pick + IdxW'(1);
        end else begin
          ptr_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      alloc_q    <= '0;
      ptr_q      <= '0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      next_q     <= 1'b0;
      first_q    <= 1'b0;
      worst_q    <= 1'b0;
      iss_q      <= '0;
      n_q        <= '0;
    end else begin
      state_q    <= state_d;
      alloc_q    <= alloc_d;
      ptr_q      <= ptr_d;
      rd_valid_q <= rd_valid_d;
      next_q     <= next_d;
      first_q    <= first_d;
      worst_q    <= worst_d;
      iss_q      <= iss_d;
      n_q        <= n_d;
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    addr_q   <= addr_d;
    rd_idx_q <= rd_idx_d;
    if (res_load) begin
      m_found_q <= m_found_d;
      m_index_q <= m_index_d;
      m_left_q  <= m_left_d;
    end
  end

  // partition size store
  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_PARTITIONS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (IdxW'(in_index)),
    .wdata_i (SIZE_BITS'(in_bsize)),
    .raddr_i (addr_q),
    .rdata_o (rd_size)
  );

  // shared compare and subtract unit
  pfa_fit_unit #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_fit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fit_ctrl),
    .req_i   (req_q),
    .size_i  (rd_size),
    .alloc_i (alloc_q[rd_idx_q]),
    .idx_i   (rd_idx_q),
    .found_o (fit_found),
    .pick_o  (fit_pick),
    .frag_o  (fit_frag)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - INDEX_W - LEFT_W){1'b0}}, m_left_q, m_index_q};

  // granted partition is marked allocated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && fit_found |=> alloc_q[$past(fit_pick)])
    else $error("granted partition not marked");

  // scan never issues beyond the active count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q < n_q))
    else $error("scan ran past the active count");

  // reads in flight only while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> ((state_q == ST_SCAN) || (state_q == ST_LAST)))
    else $error("stray size read");

  // a miss carries zero index and leftover
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("miss with non-zero payload");

endmodule
